// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the scan unit RTL.
// Both expect a signal named clk in the enclosing module; WBSS_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while reset is active.
`define WBSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define WBSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wbss_pkg.sv =====
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants of the wildcard byte signature scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbss_pkg;

    localparam int REG_PATTERN_BYTES = 24;   // pattern bytes held by the registers
    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 5;    // pattern_length field width
    localparam int CARE_W            = 24;
    localparam int OUT_OFFSET_W      = 32;   // match_offset field width
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int BYTES_PER_WORD    = CFG_DATA_W / BYTE_W;

    localparam int DEF_MAX_PATTERN_BYTES = 24;
    localparam int DEF_OFFSET_BITS       = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAT_LOW  = 3'd0,
        REG_PAT_MID  = 3'd1,
        REG_PAT_HIGH = 3'd2,
        REG_CARE     = 3'd3,
        REG_LENGTH   = 3'd4
    } cfg_reg_e;

    // Pattern view seen by every cell; length is already clamped.
    typedef struct packed {
        logic [REG_PATTERN_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [CARE_W-1:0]                        care;
        logic [LEN_W-1:0]                         length;
    } match_cfg_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] match_offset;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wbss_image_if.sv =====
// ----------------------------------------------------------------------------
// wbss_image_if
// Image byte channel: one byte per beat, last_byte closes the image.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbss_image_if;
    import wbss_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/wbss_result_if.sv =====
// ----------------------------------------------------------------------------
// wbss_result_if
// Scan result channel: one beat per match or per image ending unmatched.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbss_result_if;
    import wbss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/wbss_cell.sv =====
// ----------------------------------------------------------------------------
// wbss_cell
// One window position: holds a byte, shifts it on to the older neighbor and
// checks the incoming byte against the pattern byte aligned to this slot.
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_cell #(
    parameter int IDX = 0   // 0 is the newest byte
) (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [wbss_pkg::BYTE_W-1:0] shift_in,
    input  wbss_pkg::match_cfg_t      cfg,
    output logic [wbss_pkg::BYTE_W-1:0] byte_out,
    output logic                      ok
);
    import wbss_pkg::*;

    localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

    logic [BYTE_W-1:0] byte_reg;
    logic              active;
    logic [LEN_W-1:0]  pidx;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= shift_in;
        end
    end

    // Slot IDX meets pattern byte length-1-IDX once the shift lands.
    always_comb
    begin
        active = POS < cfg.length;
        pidx   = cfg.length - POS - LEN_W'(1);
        ok     = !active || !cfg.care[pidx] || (shift_in == cfg.pattern[pidx]);
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/wbss_out_buf.sv =====
// ----------------------------------------------------------------------------
// wbss_out_buf
// Two-entry result buffer: output register plus skid entry, so the scan
// keeps taking bytes while one result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wbss_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wbss_pkg::result_t push_data,
    output logic              space,
    wbss_result_if.source     result
);
    import wbss_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    main_take;

    assign main_take = main_valid_reg && result.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (main_take)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_data_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space               = !skid_valid_reg;
    assign result.valid        = main_valid_reg;
    assign result.found        = main_data_reg.found;
    assign result.match_offset = main_data_reg.match_offset;

    `WBSS_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid entry without output entry")
    `WBSS_ASSERT(a_push_stalled_to_skid, push && main_valid_reg && !result.ready |=> skid_valid_reg, "stalled push lost")
    `WBSS_ASSERT(a_no_push_when_full, skid_valid_reg |-> !push, "push into full buffer")

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_signature_scan_unit.sv =====
// A matching byte, or an unmatched last byte, has its result registered in the output buffer.
// Throughput: one image byte per cycle; the compare over all window cells finishes in that cycle.
// The input stalls only when both result buffer entries are full.
// Reset clears the window count, match flag, result buffer and loads register defaults
// (pattern, care mask zero, pattern_length one); no clearing pass is needed.
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_unit
// Shift window of byte cells with masked compare against a configured
// pattern; reports the first match offset or a not-found at end of image.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wildcard_byte_signature_scan_unit #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = wbss_pkg::DEF_OFFSET_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wbss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    wbss_image_if.sink                    image,
    wbss_result_if.source                 result
);
    import wbss_pkg::*;

    localparam int NCELL = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                           MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
    localparam logic [LEN_W-1:0] LEN_BOUND = LEN_W'(NCELL);
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg, pat_mid_reg, pat_high_reg;
    logic [CARE_W-1:0]     care_reg;
    logic [LEN_W-1:0]      length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            length_reg   <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_addr))
                REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                REG_PAT_MID:  pat_mid_reg  <= cfg_wdata;
                REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                REG_CARE:     care_reg     <= cfg_wdata[CARE_W-1:0];
                REG_LENGTH:   length_reg   <= cfg_wdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    match_cfg_t mcfg;

    always_comb
    begin
        for (int k = 0; k < BYTES_PER_WORD; k++)
        begin
            mcfg.pattern[k]                    = pat_low_reg[k*BYTE_W +: BYTE_W];
            mcfg.pattern[k + BYTES_PER_WORD]   = pat_mid_reg[k*BYTE_W +: BYTE_W];
            mcfg.pattern[k + 2*BYTES_PER_WORD] = pat_high_reg[k*BYTE_W +: BYTE_W];
        end
        mcfg.care = care_reg;
        // zero acts as one, anything past the window depth acts as the depth
        if (length_reg == '0)
        begin
            mcfg.length = LEN_W'(1);
        end
        else if (length_reg > LEN_BOUND)
        begin
            mcfg.length = LEN_BOUND;
        end
        else
        begin
            mcfg.length = length_reg;
        end
    end

    // window cells
    logic                          accept;
    logic                          space;
    logic [NCELL-1:0][BYTE_W-1:0]  shift_in;
    logic [NCELL-1:0][BYTE_W-1:0]  win;
    logic [NCELL-1:0]              cell_ok;

    assign accept      = image.valid && image.ready;
    assign image.ready = space;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign shift_in[gi] = image.data_byte;
            end
            else
            begin : g_link
                assign shift_in[gi] = win[gi-1];
            end

            wbss_cell #(
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .shift    (accept),
                .shift_in (shift_in[gi]),
                .cfg      (mcfg),
                .byte_out (win[gi]),
                .ok       (cell_ok[gi])
            );
        end
    endgenerate

    // scan control
    logic [OFFSET_BITS-1:0] seen_reg, seen_next, seen_inc, offset_full;
    logic                   reported_reg, reported_next;
    logic                   hit, push;
    result_t                push_data;

    always_comb
    begin
        seen_inc    = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + OFFSET_BITS'(1);
        offset_full = seen_inc - OFFSET_BITS'(mcfg.length);
        hit         = !reported_reg && (seen_inc >= OFFSET_BITS'(mcfg.length)) && (&cell_ok);
        push        = accept && (hit || (image.last_byte && !reported_reg));

        push_data.found        = hit;
        push_data.match_offset = hit ? OUT_OFFSET_W'(offset_full) : '0;

        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (image.last_byte)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_inc;
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    wbss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .result    (result)
    );

    `WBSS_ASSERT(a_last_clears_scan, accept && image.last_byte |=> (seen_reg == '0) && !reported_reg, "scan state not cleared after last byte")
    `WBSS_ASSERT(a_hit_marks_reported, accept && hit && !image.last_byte |=> reported_reg, "match not recorded")
    `WBSS_ASSERT(a_one_hit_per_image, reported_reg |-> !hit, "second match reported in one image")
    `WBSS_ASSERT(a_notfound_zero_offset, result.valid && !result.found |-> result.match_offset == '0, "not-found beat carries an offset")

endmodule

`default_nettype wire

// ===== sim/wbss_scan_checker.sv =====
// ----------------------------------------------------------------------------
// wbss_scan_checker
// Watches the configuration port and both channels of the scan unit, keeps
// its own copy of the signature registers and the scan window, and compares
// every result beat against the oldest predicted report.
// ----------------------------------------------------------------------------

module wbss_scan_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wbss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    wbss_image_if                           image,
    wbss_result_if                          result,
    output int unsigned                     error_count,
    output int unsigned                     reports_due
);
    import wbss_pkg::*;

    localparam int LEN_BOUND = (DEF_MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                               DEF_MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
    localparam int SHOWN_MISMATCHES = 10;

    logic [CFG_DATA_W-1:0]      sig_word [3];
    logic [CARE_W-1:0]          care_bits;
    logic [LEN_W-1:0]           length_reg;
    logic [BYTE_W-1:0]          window [DEF_MAX_PATTERN_BYTES];   // index 0 is newest
    logic [DEF_OFFSET_BITS-1:0] bytes_in;
    logic                       reported;
    result_t                    predicted_reports [$];
    int unsigned                failures = 0;

    function automatic logic [BYTE_W-1:0] sig_byte(input int k);
        return sig_word[k / BYTES_PER_WORD][BYTE_W * (k % BYTES_PER_WORD) +: BYTE_W];
    endfunction

    function automatic void flag(input string msg);
        if (failures < SHOWN_MISMATCHES)
            $display("%m: %s", msg);
        failures++;
    endfunction

    task automatic clear_scan();
        int k;
        for (k = 0; k < DEF_MAX_PATTERN_BYTES; k++)
            window[k] = '0;
        bytes_in = '0;
        reported = 1'b0;
    endtask

    // One image beat: shift, count, masked compare, then report or not-found.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        int      len;
        int      k;
        logic    hit;
        result_t rep;
        len = int'(length_reg);
        if (len < 1)
            len = 1;
        if (len > LEN_BOUND)
            len = LEN_BOUND;
        for (k = DEF_MAX_PATTERN_BYTES - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = b;
        if (bytes_in != '1)
            bytes_in++;
        hit = 1'b0;
        if (!reported && bytes_in >= DEF_OFFSET_BITS'(len))
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (care_bits[k] && window[len - 1 - k] != sig_byte(k))
                    hit = 1'b0;
        end
        if (hit)
        begin
            rep.found = 1'b1;
            rep.match_offset = OUT_OFFSET_W'(bytes_in - DEF_OFFSET_BITS'(len));
            predicted_reports = {predicted_reports, rep};
            reported = 1'b1;
        end
        else if (last && !reported)
        begin
            rep.found = 1'b0;
            rep.match_offset = '0;
            predicted_reports = {predicted_reports, rep};
        end
        if (last)
            clear_scan();
    endtask

    task automatic check_report(input logic found, input logic [OUT_OFFSET_W-1:0] offset);
        result_t want;
        if (predicted_reports.size() == 0)
        begin
            flag($sformatf("result beat with none pending: found=%0b match_offset=%0d",
                           found, offset));
            return;
        end
        want = predicted_reports.pop_front();
        if (found !== want.found)
            flag($sformatf("found: expected %0b, got %0b", want.found, found));
        if (offset !== want.match_offset)
            flag($sformatf("match_offset: expected %0d, got %0d", want.match_offset, offset));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_word[0] = '0;
            sig_word[1] = '0;
            sig_word[2] = '0;
            care_bits = '0;
            length_reg = LEN_W'(1);
            clear_scan();
            predicted_reports.delete();
        end
        else
        begin
            // result beats always belong to earlier image beats, so check first
            if (result.valid && result.ready)
                check_report(result.found, result.match_offset);
            if (image.valid && image.ready)
                scan_byte(image.data_byte, image.last_byte);
            if (cfg_we)
            begin
                case (cfg_reg_e'(cfg_addr))
                    REG_PAT_LOW:  sig_word[0] = cfg_wdata;
                    REG_PAT_MID:  sig_word[1] = cfg_wdata;
                    REG_PAT_HIGH: sig_word[2] = cfg_wdata;
                    REG_CARE:     care_bits = cfg_wdata[CARE_W-1:0];
                    REG_LENGTH:   length_reg = cfg_wdata[LEN_W-1:0];
                    default:      ;
                endcase
            end
        end
        error_count <= failures;
        reports_due <= predicted_reports.size();
    end

endmodule

// ===== sim/wildcard_byte_signature_scan_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_unit_tb
// Drives images into the scan unit under several signature settings and
// flow-control mixes: a directed set of corner images first, then random
// images that mostly carry a planted signature. The checker predicts each
// report; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module wildcard_byte_signature_scan_unit_tb;
    import wbss_pkg::*;

    localparam int LEN_BOUND = (DEF_MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                               DEF_MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_ITEMS  = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int unsigned           error_count;
    int unsigned           reports_due;
    int unsigned           idle_pct;
    int unsigned           stall_pct;
    logic                  hold_on;

    // local copy of the signature, used only to plant matches
    logic [CFG_DATA_W-1:0] sig_words [3];
    logic [CARE_W-1:0]     care_now;
    int unsigned           sig_len;
    logic [BYTE_W-1:0]     image_bytes [$];
    int unsigned           scan_items;

    wbss_image_if  image_ch ();
    wbss_result_if result_ch ();

    wildcard_byte_signature_scan_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .image     (image_ch),
        .result    (result_ch)
    );

    wbss_scan_checker scan_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .image       (image_ch),
        .result      (result_ch),
        .error_count (error_count),
        .reports_due (reports_due)
    );

    always #2 clk = ~clk;

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, then wait until every predicted report has come back.
    task automatic wait_drained();
        image_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_signature(input logic [CFG_DATA_W-1:0] lo,
                                  input logic [CFG_DATA_W-1:0] mid,
                                  input logic [CFG_DATA_W-1:0] hi,
                                  input logic [CARE_W-1:0] care,
                                  input logic [LEN_W-1:0] len);
        wait_drained();
        write_reg(REG_PAT_LOW, lo);
        write_reg(REG_PAT_MID, mid);
        write_reg(REG_PAT_HIGH, hi);
        write_reg(REG_CARE, CFG_DATA_W'(care));
        write_reg(REG_LENGTH, CFG_DATA_W'(len));
        sig_words[0] = lo;
        sig_words[1] = mid;
        sig_words[2] = hi;
        care_now = care;
        if (len == 0)
            sig_len = 1;
        else if (len > LEN_BOUND)
            sig_len = LEN_BOUND;
        else
            sig_len = len;
    endtask

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            image_ch.valid <= 1'b0;
            @(posedge clk);
        end
        image_ch.valid <= 1'b1;
        image_ch.data_byte <= b;
        image_ch.last_byte <= last;
        @(posedge clk);
        while (!image_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_image();
        int unsigned i;
        for (i = 0; i < image_bytes.size(); i++)
            send_beat(image_bytes[i], i == image_bytes.size() - 1);
    endtask

    // Mostly a planted signature in random filler; some with one cared bit
    // flipped, the rest plain noise. Lengths mostly stay near the pattern length.
    task automatic make_image();
        int unsigned n;
        int unsigned at;
        int unsigned j;
        int unsigned flavor;
        flavor = $urandom_range(99);
        if ($urandom_range(19) == 0)
            n = $urandom_range(1, 64);
        else
            n = $urandom_range(1, sig_len + 8);
        image_bytes.delete();
        repeat (n) image_bytes = {image_bytes, BYTE_W'($urandom)};
        if (flavor < 75 && n >= sig_len)
        begin
            at = $urandom_range(n - sig_len);
            for (j = 0; j < sig_len; j++)
                if (care_now[j])
                    image_bytes[at + j] =
                        sig_words[j / BYTES_PER_WORD][BYTE_W * (j % BYTES_PER_WORD) +: BYTE_W];
            if (flavor < 15)
            begin
                j = $urandom_range(sig_len - 1);
                if (care_now[j])
                    image_bytes[at + j] ^= 8'h01 << $urandom_range(7);
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off counted here while hold_on is set.
    initial
    begin : receiver
        int unsigned held;
        held = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_on && held < HOLD_CYCLES)
            begin
                result_ch.ready <= 1'b0;
                held++;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
                if (!hold_on)
                    held = 0;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned p;
        int unsigned phase_items;
        int unsigned len;
        logic [CARE_W-1:0] care;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        image_ch.valid = 1'b0;
        image_ch.data_byte = '0;
        image_ch.last_byte = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_on = 1'b0;
        scan_items = 0;
        sig_words[0] = '0;
        sig_words[1] = '0;
        sig_words[2] = '0;
        care_now = '0;
        sig_len = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: all wildcards, so the first byte matches
        image_bytes = '{8'h00, 8'hFF};
        send_image();

        // length 0 acts as 1; match mid-image, then a one-byte image that misses
        load_signature(64'hFF, 64'h0, 64'h0, 24'h000001, 5'd0);
        image_bytes = '{8'h00, 8'h7F, 8'hFF, 8'hFF};
        send_image();
        image_bytes = '{8'h00};
        send_image();

        // 3-byte pattern with a wildcard in the middle
        load_signature(64'h00FF_EE12, '1, '1, 24'h000005, 5'd3);
        image_bytes = '{8'h12, 8'h00};                       // shorter than the pattern
        send_image();
        image_bytes = '{8'h12, 8'hAB, 8'hFF};                // match ends on the last byte
        send_image();
        image_bytes = '{8'h00, 8'h12, 8'h99, 8'h00};
        send_image();
        image_bytes = '{8'h12, 8'h01, 8'hFF, 8'h12, 8'h02, 8'hFF};   // second match ignored
        send_image();

        // pattern changed between two beats of one image
        load_signature(64'h2211, 64'h0, 64'h0, 24'h000003, 5'd2);
        send_beat(8'h34, 1'b0);
        wait_drained();
        write_reg(REG_PAT_LOW, 64'h5634);
        send_beat(8'h56, 1'b1);

        p = 0;
        while (scan_items < RANDOM_ITEMS)
        begin
            if (p == 5)
            begin
                // receiver holds off long enough for the result buffer to fill
                load_signature({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, 24'h0, 5'd1);
                idle_pct = 0;
                stall_pct <= 0;
                hold_on <= 1'b1;
                repeat (30)
                begin
                    image_bytes.delete();
                    repeat ($urandom_range(1, 3)) image_bytes = {image_bytes, BYTE_W'($urandom)};
                    send_image();
                end
                hold_on <= 1'b0;
            end

            case (p)
                0: load_signature('0, '0, '0, '1, 5'd24);
                1: load_signature('1, '1, '1, '1, 5'd31);
                2: load_signature({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, '0, 5'd0);
                3: load_signature({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, CARE_W'($urandom), 5'd25);
                default:
                begin
                    if ($urandom_range(3) == 0)
                        len = $urandom_range(9, LEN_BOUND);
                    else
                        len = $urandom_range(1, 8);
                    if ($urandom_range(1) == 0)
                        care = CARE_W'($urandom | $urandom);
                    else
                        care = CARE_W'($urandom);
                    load_signature({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, care, LEN_W'(len));
                end
            endcase

            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 60;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 60;
                end
                default:
                begin
                    idle_pct = 33;
                    stall_pct <= 33;
                end
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                make_image();
                send_image();
                phase_items += image_bytes.size();
            end
            scan_items += phase_items;
            p++;
        end

        wait_drained();
        if (error_count == 0)
            $display("wildcard_byte_signature_scan_unit_tb: clean");
        else
            $display("wildcard_byte_signature_scan_unit_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("wildcard_byte_signature_scan_unit_tb: errors");
        $finish;
    end

endmodule
